// ===== rtl/ttl_pkg.sv =====
// Shared types, constants and helpers for the tiled-to-linear pixel address block.
package ttl_pkg;

  localparam int COORD_BITS  = 12;
  localparam int PIXEL_BITS  = 32;
  localparam int WORD_BITS   = 11;
  localparam int COL_BITS    = 7;
  localparam int ROW_BITS    = 6;
  localparam int WIDTH_BITS  = 8;
  localparam int HEIGHT_BITS = 7;

  // x and y fit exactly in 12 bits before the coordinate mask
  localparam int GEOM_BITS = 12;
  localparam int CALC_BITS = (COORD_BITS > GEOM_BITS) ? COORD_BITS : GEOM_BITS;

  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 8;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [WIDTH_BITS-1:0]  MAX_WIDTH_TILES    = 8'd128;
  localparam logic [HEIGHT_BITS-1:0] MAX_HEIGHT_TILES   = 7'd64;
  localparam logic [WIDTH_BITS-1:0]  RESET_WIDTH_TILES  = 8'd40;
  localparam logic [HEIGHT_BITS-1:0] RESET_HEIGHT_TILES = 7'd12;
  localparam logic [WORD_BITS-1:0]   LAST_WORD_IN_TILE  = 11'd2047;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [WIDTH_BITS-1:0]  width;
    logic [HEIGHT_BITS-1:0] height;
  } ttl_limits_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel;
    logic [WORD_BITS-1:0]  word_idx;
    logic [COL_BITS-1:0]   tile_col;
    logic [ROW_BITS-1:0]   tile_row;
    logic                  last;
  } ttl_entry_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] word_in_tile;
    logic [COL_BITS-1:0]  tile_column;
    logic [ROW_BITS-1:0]  tile_row;
  } ttl_front_stat_t;

  function automatic logic [2:0] rev3(input logic [2:0] v);
    return {v[0], v[1], v[2]};
  endfunction

endpackage

// ===== rtl/ttl_in_if.sv =====
// Input channel: tiled pixel words with frame start marker.
interface ttl_in_if;
  import ttl_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_word;
  logic                  frame_start;
  modport source (output valid, output pixel_word, output frame_start, input ready);
  modport sink   (input valid, input pixel_word, input frame_start, output ready);
endinterface

// ===== rtl/ttl_out_if.sv =====
// Output channel: pixel words tagged with linear coordinates.
interface ttl_out_if;
  import ttl_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_out;
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;
  logic                  frame_last;
  modport source (output valid, output pixel_out, output pos_x, output pos_y,
                  output frame_last, input ready);
  modport sink   (input valid, input pixel_out, input pos_x, input pos_y,
                  input frame_last, output ready);
endinterface

// ===== rtl/ttl_cfg_if.sv =====
// Configuration write channel.
interface ttl_cfg_if;
  import ttl_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/tiled_to_linear_pixel_address.sv =====
// Top level of the tiled-to-linear pixel address block.
// Takes one 32-bit pixel word per clock in tiled order, while the queue has
// room, and returns it tagged with its linear x,y position, one result per
// item, in order. Throughput is one item per cycle while the output is not
// stalled. An accepted item is written into the queue and from there loaded
// into the output register, where it is offered at the output.
// Output stalls fill the queue and then hold off the input.
// The front end holds the position counters, a four-entry queue decouples it
// from the back end that does the coordinate mapping and drives the output
// register. Frame size registers (index 0: width in 32-pixel tiles, index 1:
// height in 64-row tiles) clamp 0 to 1 and large values to 128 and 64, and
// should be written only while no items are in flight.
module tiled_to_linear_pixel_address (
  input logic      clk,
  input logic      rst,
  ttl_in_if.sink   pix_in,
  ttl_out_if.source pix_out,
  ttl_cfg_if.sink  cfg
);
  import ttl_pkg::*;

  logic [WIDTH_BITS-1:0]  frame_width_tiles;
  logic [HEIGHT_BITS-1:0] frame_height_tiles;
  ttl_limits_t            limits;
  ttl_front_stat_t        stat;

  logic       push_valid, push_ready;
  ttl_entry_t push_data;
  logic       pop_valid, pop_ready;
  ttl_entry_t pop_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width_tiles  <= RESET_WIDTH_TILES;
      frame_height_tiles <= RESET_HEIGHT_TILES;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_FRAME_WIDTH:  frame_width_tiles  <= cfg.data;
        REG_FRAME_HEIGHT: frame_height_tiles <= cfg.data[HEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width_tiles == '0) begin
      limits.width = WIDTH_BITS'(1);
    end else if (frame_width_tiles > MAX_WIDTH_TILES) begin
      limits.width = MAX_WIDTH_TILES;
    end else begin
      limits.width = frame_width_tiles;
    end
    if (frame_height_tiles == '0) begin
      limits.height = HEIGHT_BITS'(1);
    end else if (frame_height_tiles > MAX_HEIGHT_TILES) begin
      limits.height = MAX_HEIGHT_TILES;
    end else begin
      limits.height = frame_height_tiles;
    end
  end

  ttl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pix_in     (pix_in),
    .limits     (limits),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .stat       (stat)
  );

  ttl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  ttl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .pix_out   (pix_out)
  );

  // the last word of a frame is always the bottom-right word of a micro tile
  a_last_corner: assert property (@(posedge clk) disable iff (rst)
    (pix_out.valid && pix_out.frame_last) |->
      (pix_out.pos_x[2:0] == 3'd7 && pix_out.pos_y[2:0] == 3'd7))
    else $error("frame_last on a word that is not a micro tile corner");

  // a flagged last item wraps every counter back to the frame origin
  a_wrap_origin: assert property (@(posedge clk) disable iff (rst)
    (push_valid && push_ready && push_data.last) |=>
      (stat.word_in_tile == '0 && stat.tile_column == '0 && stat.tile_row == '0))
    else $error("counters did not wrap after the last word of a frame");

  // an empty output register is refilled at once from a non-empty queue
  a_back_drains: assert property (@(posedge clk) disable iff (rst)
    (pop_valid && !pix_out.valid) |=> pix_out.valid)
    else $error("back end idled with items queued");

endmodule

// ===== rtl/ttl_front.sv =====
// Front end: position counters and per-item classification.
module ttl_front (
  input  logic                     clk,
  input  logic                     rst,
  ttl_in_if.sink                   pix_in,
  input  ttl_pkg::ttl_limits_t     limits,
  output logic                     push_valid,
  input  logic                     push_ready,
  output ttl_pkg::ttl_entry_t      push_data,
  output ttl_pkg::ttl_front_stat_t stat
);
  import ttl_pkg::*;

  logic [WORD_BITS-1:0] word_in_tile, word_in_tile_next;
  logic [COL_BITS-1:0]  tile_column, tile_column_next;
  logic [ROW_BITS-1:0]  tile_row, tile_row_next;

  logic [WORD_BITS-1:0] base_word;
  logic [COL_BITS-1:0]  base_col;
  logic [ROW_BITS-1:0]  base_row;
  logic                 last_word, last_col, last_row;
  logic                 accept;

  assign pix_in.ready = push_ready;
  assign push_valid   = pix_in.valid;
  assign accept       = pix_in.valid && push_ready;

  always_comb begin
    // frame start restarts the counters before this item is placed
    if (pix_in.frame_start) begin
      base_word = '0;
      base_col  = '0;
      base_row  = '0;
    end else begin
      base_word = word_in_tile;
      base_col  = tile_column;
      base_row  = tile_row;
    end
    last_word = (base_word == LAST_WORD_IN_TILE);
    last_col  = ({1'b0, base_col} + WIDTH_BITS'(1)) >= limits.width;
    last_row  = ({1'b0, base_row} + HEIGHT_BITS'(1)) >= limits.height;

    word_in_tile_next = base_word + WORD_BITS'(1);
    tile_column_next  = base_col;
    tile_row_next     = base_row;
    if (last_word) begin
      word_in_tile_next = '0;
      if (!last_col) begin
        tile_column_next = base_col + COL_BITS'(1);
      end else begin
        tile_column_next = '0;
        tile_row_next    = last_row ? '0 : base_row + ROW_BITS'(1);
      end
    end
  end

  assign push_data.pixel    = pix_in.pixel_word;
  assign push_data.word_idx = base_word;
  assign push_data.tile_col = base_col;
  assign push_data.tile_row = base_row;
  assign push_data.last     = last_word && last_col && last_row;

  assign stat.word_in_tile = word_in_tile;
  assign stat.tile_column  = tile_column;
  assign stat.tile_row     = tile_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_in_tile <= '0;
      tile_column  <= '0;
      tile_row     <= '0;
    end else if (accept) begin
      word_in_tile <= word_in_tile_next;
      tile_column  <= tile_column_next;
      tile_row     <= tile_row_next;
    end
  end

endmodule

// ===== rtl/ttl_queue.sv =====
// Short queue between the front and back ends.
module ttl_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  ttl_pkg::ttl_entry_t push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output ttl_pkg::ttl_entry_t pop_data
);
  import ttl_pkg::*;

  ttl_entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr;
  logic [QPTR_BITS-1:0]  rd_ptr;
  logic [QCNT_BITS-1:0]  count;
  logic                  do_push, do_pop;

  assign push_ready = (count != QCNT_BITS'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_BITS'(1);
      end
    end
  end

endmodule

// ===== rtl/ttl_back.sv =====
// Back end: maps tile position to linear x,y and holds the output register.
module ttl_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  ttl_pkg::ttl_entry_t pop_data,
  ttl_out_if.source           pix_out
);
  import ttl_pkg::*;

  logic [4:0]           micro_idx;
  logic [5:0]           micro_word;
  logic [2:0]           in_row, in_col;
  logic [2:0]           micro_row, placed_row;
  logic [1:0]           flip, micro_col;
  logic [GEOM_BITS-1:0] x_geom, y_geom;
  logic [CALC_BITS-1:0] x_full, y_full;

  logic                  out_valid;
  logic [PIXEL_BITS-1:0] pixel_q;
  logic [COORD_BITS-1:0] pos_x_q, pos_y_q;
  logic                  last_q;

  always_comb begin
    micro_idx  = pop_data.word_idx[10:6];
    micro_word = pop_data.word_idx[5:0];
    in_row     = {micro_word[5:4], micro_word[2]};
    in_col     = {micro_word[3], micro_word[1:0]};
    micro_row  = micro_idx[4:2];
    // odd tile rows swap column pairs; micro tiles placed on odd rows swap neighbours
    flip       = {pop_data.tile_row[0], micro_row[2]};
    micro_col  = micro_idx[1:0] ^ flip;
    placed_row = rev3(micro_row ^ {1'b0, pop_data.tile_col[1:0]}
                      ^ {2'b00, pop_data.tile_row[0]});
    x_geom     = {pop_data.tile_col, micro_col, in_col};
    y_geom     = {pop_data.tile_row, placed_row, in_row};
    x_full     = CALC_BITS'(x_geom);
    y_full     = CALC_BITS'(y_geom);
  end

  assign pop_ready = !out_valid || pix_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop_ready) begin
      out_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) begin
      pixel_q <= pop_data.pixel;
      pos_x_q <= x_full[COORD_BITS-1:0];
      pos_y_q <= y_full[COORD_BITS-1:0];
      last_q  <= pop_data.last;
    end
  end

  assign pix_out.valid      = out_valid;
  assign pix_out.pixel_out  = pixel_q;
  assign pix_out.pos_x      = pos_x_q;
  assign pix_out.pos_y      = pos_y_q;
  assign pix_out.frame_last = last_q;

endmodule
